/* rtl/lgge_pkg.sv */
// Shared types and constants for the life grid generation engine.
// No dependencies; imported by every lgge module and the top level.
package lgge_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  // Fixed request field widths
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;

  localparam int ROW_IDX_W = $clog2(GRID_HEIGHT);
  localparam int COL_IDX_W = $clog2(GRID_WIDTH);
  // Common width for comparing a request row against the sweep position
  localparam int ROW_CMP_W = (ROW_IDX_W > COORD_W) ? ROW_IDX_W : COORD_W;
  // Count of live neighbors: at most 8
  localparam int NBR_CNT_W = 4;

  localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = NBR_CNT_W'(3);
  localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = NBR_CNT_W'(2);

  typedef logic [GRID_WIDTH-1:0] row_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

endpackage

/* rtl/life_grid_generation_engine.sv */
// Life grid generation engine: a GRID_HEIGHT x GRID_WIDTH grid of one-bit
// cells (B3/S23, dead border, no wrap-around), dead after reset. The rows sit
// in a ring of row cells that rotates one row per cycle while a request runs;
// every request (write cell, read cell, advance one generation, or the unused
// code) runs one full turn of the ring: the request is accepted, and then the
// ring shifts until every grid row has passed through the head. During a
// generation turn the rule unit builds the new row from the row leaving the
// head, the row behind it and a saved copy of the row before it, and feeds the
// new row into the tail. A write or read acts on the head when the addressed
// row passes. Each request answers once: the cell value for read or write, 0
// for a generation step, an unused code or an off-grid coordinate. The answer
// waits in an output register, so the next request can start while it is
// unclaimed; only the end of a turn holds off when that register is full.
// Depends on lgge_pkg, lgge_row_cell and lgge_rule.
module life_grid_generation_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lgge_pkg::CMD_W-1:0]  in_command,
  input  logic [lgge_pkg::COORD_W-1:0] in_column,
  input  logic [lgge_pkg::COORD_W-1:0] in_row,
  input  logic                        in_alive_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_cell_alive
);
  import lgge_pkg::*;

  // Sequencer state
  state_t               state_r, state_nxt;
  logic [ROW_IDX_W-1:0] count_r, count_nxt;

  // Latched request
  cmd_t               cmd_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic               alive_r;
  logic               res_r, res_nxt;

  // Original copy of the row that left the head on the previous shift
  row_t prev_r, prev_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_alive_r, out_alive_nxt;

  // Ring of row cells; ring[0] is the head
  row_t ring [GRID_HEIGHT];
  row_t tail_in;
  row_t head;
  row_t above;
  row_t below;
  row_t gen_row;
  row_t wr_mask;
  row_t wr_row;

  logic accept;
  logic sweeping;
  logic last;
  logic out_blocked;
  logic shift_en;
  logic finish;
  logic row_hit;
  logic col_ok;
  logic head_bit;

  assign accept      = in_valid && in_ready;
  assign sweeping    = (state_r == ST_SWEEP);
  assign last        = (count_r == ROW_IDX_W'(GRID_HEIGHT - 1));
  assign out_blocked = out_valid_r && !out_ready;
  // The last shift waits until the output register can take the answer
  assign shift_en    = sweeping && !(last && out_blocked);
  assign finish      = sweeping && last && !out_blocked;

  for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_ring
    row_t link_in;
    if (i == GRID_HEIGHT - 1) begin : g_tail
      assign link_in = tail_in;
    end else begin : g_link
      assign link_in = ring[i+1];
    end
    lgge_row_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .row_in   (link_in),
      .row_out  (ring[i])
    );
  end

  assign head = ring[0];
  // Row 0 has nothing above; the last row has nothing below (ring[1] then
  // already holds the new row 0)
  assign above = (count_r == '0) ? '0 : prev_r;
  assign below = last ? '0 : ring[1];

  lgge_rule u_rule (
    .above    (above),
    .center   (head),
    .below    (below),
    .next_row (gen_row)
  );

  // Addressing: the head carries grid row count_r
  assign row_hit  = (ROW_CMP_W'(row_r) == ROW_CMP_W'(count_r));
  assign col_ok   = ((COORD_W+1)'(col_r) < (COORD_W+1)'(GRID_WIDTH));
  assign head_bit = head[col_r[COL_IDX_W-1:0]];
  assign wr_mask  = row_t'(1) << col_r[COL_IDX_W-1:0];
  assign wr_row   = alive_r ? (head | wr_mask) : (head & ~wr_mask);

  always_comb begin
    tail_in = head;
    res_nxt = res_r;
    case (cmd_r)
      CMD_STEP: begin
        tail_in = gen_row;
      end
      CMD_WRITE: begin
        if (row_hit && col_ok) begin
          tail_in = wr_row;
          res_nxt = alive_r;
        end
      end
      CMD_READ: begin
        if (row_hit && col_ok) begin
          res_nxt = head_bit;
        end
      end
      default: begin
        tail_in = head;
      end
    endcase
    if (!sweeping) begin
      res_nxt = res_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SWEEP: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = '0;
    end else if (shift_en && !last) begin
      count_nxt = count_r + ROW_IDX_W'(1);
    end
    prev_nxt = shift_en ? head : prev_r;

    out_valid_nxt = out_valid_r;
    out_alive_nxt = out_alive_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_alive_nxt = res_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_command);
      col_r   <= in_column;
      row_r   <= in_row;
      alive_r <= in_alive_in;
      res_r   <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
    prev_r      <= prev_nxt;
    out_alive_r <= out_alive_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_alive_r;

endmodule

/* rtl/lgge_row_cell.sv */
// One row of the grid, held as a link in the rotating row chain.
// Depends on lgge_pkg.
module lgge_row_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  lgge_pkg::row_t row_in,
  output lgge_pkg::row_t row_out
);
  import lgge_pkg::*;

  row_t row_r;
  row_t row_nxt;

  always_comb begin
    row_nxt = shift_en ? row_in : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_out = row_r;

endmodule

/* rtl/lgge_rule.sv */
// B3/S23 rule for one whole row: next row from the rows above, at and below.
// Depends on lgge_pkg. Cells beyond the row edges count as dead.
module lgge_rule (
  input  lgge_pkg::row_t above,
  input  lgge_pkg::row_t center,
  input  lgge_pkg::row_t below,
  output lgge_pkg::row_t next_row
);
  import lgge_pkg::*;

  logic [GRID_WIDTH+1:0] above_pad;
  logic [GRID_WIDTH+1:0] center_pad;
  logic [GRID_WIDTH+1:0] below_pad;

  // Padded bit c+1 is grid column c
  assign above_pad  = {1'b0, above, 1'b0};
  assign center_pad = {1'b0, center, 1'b0};
  assign below_pad  = {1'b0, below, 1'b0};

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    logic [NBR_CNT_W-1:0] cnt;
    always_comb begin
      cnt = NBR_CNT_W'(above_pad[c])  + NBR_CNT_W'(above_pad[c+1])
          + NBR_CNT_W'(above_pad[c+2]) + NBR_CNT_W'(center_pad[c])
          + NBR_CNT_W'(center_pad[c+2]) + NBR_CNT_W'(below_pad[c])
          + NBR_CNT_W'(below_pad[c+1])  + NBR_CNT_W'(below_pad[c+2]);
    end
    assign next_row[c] = (cnt == BIRTH_COUNT) || (center[c] && (cnt == SURVIVE_COUNT));
  end

endmodule

/* sim/life_grid_generation_engine_checker.sv */
// Scoreboard for the life grid generation engine: mirrors the cell grid,
// predicts each request's answer and compares it with the result channel.
// Depends on lgge_pkg.
`timescale 1ns / 1ps

module life_grid_generation_engine_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [lgge_pkg::CMD_W-1:0]   in_command,
  input  logic [lgge_pkg::COORD_W-1:0] in_column,
  input  logic [lgge_pkg::COORD_W-1:0] in_row,
  input  logic                         in_alive_in,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_cell_alive,
  output int                           mismatches,
  output int                           outstanding,
  output int                           checked
);
  import lgge_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               cell_alive;
  } cell_answer_t;

  row_t         life_grid [GRID_HEIGHT];
  cell_answer_t answer_q [$];
  int           fail_count;
  int           answer_count;

  function automatic int live_at(int r, int c);
    if (r < 0 || r >= GRID_HEIGHT || c < 0 || c >= GRID_WIDTH) return 0;
    return int'(life_grid[r][c]);
  endfunction

  // B3/S23 over the whole grid; dead border, every new row from the old grid
  function automatic void evolve_grid();
    row_t next_gen [GRID_HEIGHT];
    int   nbrs;
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      next_gen[r] = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
        nbrs = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) nbrs += live_at(r + dr, c + dc);
        next_gen[r][c] = (nbrs == 3) || (life_grid[r][c] && nbrs == 2);
      end
    end
    life_grid = next_gen;
  endfunction

  function automatic logic apply_request(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] col,
                                         logic [COORD_W-1:0] row, logic alive);
    logic answer;
    logic on_grid;
    answer  = 1'b0;
    on_grid = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
    case (cmd)
      CMD_WRITE: begin
        if (on_grid) begin
          life_grid[row][col] = alive;
          answer = alive;
        end
      end
      CMD_STEP: evolve_grid();
      CMD_READ: begin
        if (on_grid) answer = life_grid[row][col];
      end
      default: ;
    endcase
    return answer;
  endfunction

  always @(posedge clk) begin
    cell_answer_t want;
    if (!rst_n) begin
      for (int r = 0; r < GRID_HEIGHT; r++) life_grid[r] = '0;
      answer_q.delete();
      fail_count   = 0;
      answer_count = 0;
    end else begin
      // results first: a request accepted on this edge cannot answer on it
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with no request waiting: expected none, actual cell_alive=%0b",
                   $time, out_cell_alive);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          answer_count++;
          if (out_cell_alive !== want.cell_alive) begin
            $display("%0t: cmd %0d col %0d row %0d: expected cell_alive=%0b, actual %0b",
                     $time, want.command, want.column, want.row, want.cell_alive,
                     out_cell_alive);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want.command    = in_command;
        want.column     = in_column;
        want.row        = in_row;
        want.cell_alive = apply_request(in_command, in_column, in_row, in_alive_in);
        answer_q.push_back(want);
      end
    end
    mismatches  <= fail_count;
    outstanding <= answer_q.size();
    checked     <= answer_count;
  end

endmodule

/* sim/life_grid_generation_engine_tb.sv */
// Testbench top for the life grid generation engine: drives write, read,
// step and unused-code requests with random idling on both sides.
// Depends on lgge_pkg, the engine RTL and life_grid_generation_engine_checker.
`timescale 1ns / 1ps

module life_grid_generation_engine_tb;
  import lgge_pkg::*;

  // Code the block must answer with 0 and otherwise ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_REQUESTS = 1250;
  // Request turns, gaps and stalls all stay well short of this limit, so a run
  // of quiet cycles that reaches it means the block is stuck.
  localparam int STALL_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = GRID_HEIGHT + 16;
  localparam int COORD_SPAN      = 1 << COORD_W;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command;
  logic [COORD_W-1:0] in_column;
  logic [COORD_W-1:0] in_row;
  logic               in_alive_in;
  logic               out_valid;
  logic               out_ready;
  logic               out_cell_alive;

  int mismatches;
  int outstanding;
  int checked;

  // Sender bookkeeping
  int next_gap;
  bit no_idle;
  int sent_count;
  int write_count;
  int read_count;
  int step_count;
  int unused_count;
  int drain_count;
  int idle_cycles;

  life_grid_generation_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_alive_in    (in_alive_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive)
  );

  life_grid_generation_engine_checker grid_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_alive_in    (in_alive_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long enough to cover
  // several request turns. quiet forces back-to-back traffic.
  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  // One request on the input channel. valid drops right after acceptance only
  // when an idle gap follows, so valid never toggles within one time step.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] col,
                              logic [COORD_W-1:0] row, logic alive);
    repeat (next_gap) @(posedge clk);
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_column   <= col;
    in_row      <= row;
    in_alive_in <= alive;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    case (cmd)
      CMD_WRITE: write_count++;
      CMD_READ:  read_count++;
      CMD_STEP:  step_count++;
      default:   unused_count++;
    endcase
    next_gap = pick_gap(no_idle);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  // Hold off the sender until every accepted request has been answered
  task automatic drain_requests();
    if (next_gap == 0) in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    next_gap = 0;
    drain_count++;
  endtask

  // Stimulus
  initial begin
    int roll;
    int span;
    int x0;
    int y0;
    int burst_len;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_command  <= CMD_WRITE;
    in_column   <= '0;
    in_row      <= '0;
    in_alive_in <= 1'b0;
    next_gap     = 0;
    no_idle      = 1'b0;
    sent_count   = 0;
    write_count  = 0;
    read_count   = 0;
    step_count   = 0;
    unused_count = 0;
    drain_count  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fresh grid must read dead at both far corners
    send_request(CMD_READ, 6'd0, 6'd0, 1'b1);
    send_request(CMD_READ, 6'd63, 6'd63, 1'b0);
    // Horizontal blinker pressed against the top-left corner: one of the three
    // cells of its vertical phase falls off the grid
    send_request(CMD_WRITE, 6'd0, 6'd0, 1'b1);
    send_request(CMD_WRITE, 6'd1, 6'd0, 1'b1);
    send_request(CMD_WRITE, 6'd2, 6'd0, 1'b1);
    // Still-life block in the bottom-right corner
    send_request(CMD_WRITE, 6'd62, 6'd62, 1'b1);
    send_request(CMD_WRITE, 6'd63, 6'd62, 1'b1);
    send_request(CMD_WRITE, 6'd62, 6'd63, 1'b1);
    send_request(CMD_WRITE, 6'd63, 6'd63, 1'b1);
    // Lonely cell on the top-right corner dies of isolation
    send_request(CMD_WRITE, 6'd63, 6'd0, 1'b1);
    // Set then clear a cell in the middle
    send_request(CMD_WRITE, 6'd40, 6'd20, 1'b1);
    send_request(CMD_WRITE, 6'd40, 6'd20, 1'b0);
    send_request(CMD_READ, 6'd40, 6'd20, 1'b1);
    // Unused code with every payload bit set must not touch the grid
    send_request(CMD_UNUSED, 6'd63, 6'd63, 1'b1);
    send_request(CMD_READ, 6'd63, 6'd63, 1'b0);
    send_request(CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_request(CMD_READ, 6'd1, 6'd0, 1'b0);
    send_request(CMD_READ, 6'd1, 6'd1, 1'b0);
    send_request(CMD_READ, 6'd0, 6'd0, 1'b0);
    send_request(CMD_READ, 6'd63, 6'd0, 1'b0);
    send_request(CMD_READ, 6'd62, 6'd63, 1'b0);
    send_request(CMD_STEP, 6'd63, 6'd63, 1'b1);
    send_request(CMD_READ, 6'd0, 6'd0, 1'b0);
    drain_requests();

    // Random: mostly seeded patches that get evolved and probed, some noise,
    // and the occasional full drain.
    while (sent_count < 23 + RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      roll    = $urandom_range(0, 99);
      if (roll < 70) begin
        span = $urandom_range(3, 10);
        case ($urandom_range(0, 3))
          0:       x0 = 0;
          1:       x0 = COORD_SPAN - span;
          default: x0 = $urandom_range(0, COORD_SPAN - span);
        endcase
        case ($urandom_range(0, 3))
          0:       y0 = 0;
          1:       y0 = COORD_SPAN - span;
          default: y0 = $urandom_range(0, COORD_SPAN - span);
        endcase
        repeat ($urandom_range(3, 16))
          send_request(CMD_WRITE, COORD_W'(x0 + $urandom_range(0, span - 1)),
                       COORD_W'(y0 + $urandom_range(0, span - 1)),
                       $urandom_range(0, 4) != 0);
        repeat ($urandom_range(1, 3)) begin
          send_request(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
          // probe the patch and a one-cell ring around it
          repeat ($urandom_range(2, 8))
            send_request(CMD_READ, COORD_W'(x0 - 1 + $urandom_range(0, span + 1)),
                         COORD_W'(y0 - 1 + $urandom_range(0, span + 1)), 1'($urandom));
        end
      end else if (roll < 93) begin
        burst_len = $urandom_range(3, 12);
        repeat (burst_len)
          send_request(CMD_W'($urandom_range(0, 3)), COORD_W'($urandom),
                       COORD_W'($urandom), 1'($urandom));
      end else begin
        drain_requests();
      end
    end

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d writes, %0d reads, %0d generation steps, %0d unused",
             sent_count, write_count, read_count, step_count, unused_count);
    $display("Checked %0d results; sender drained the block %0d times", checked, drain_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: ready in runs, with stalls mostly short and a few long
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else begin
        stall = pick_gap(1'b0);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Watchdog on quiet cycles: neither a request nor a result accepted
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/lgge_pkg.sv
rtl/lgge_row_cell.sv
rtl/lgge_rule.sv
rtl/life_grid_generation_engine.sv
sim/life_grid_generation_engine_checker.sv
sim/life_grid_generation_engine_tb.sv
